// File: design/frf_pkg.sv
// Shared types and constants for the flood relay filter.
// No dependencies; imported by frf_seen and flood_relay_filter_core.
`timescale 1ns / 1ps

package frf_pkg;

   // relay queue size is tied to the 2-bit slot field of a result beat
   localparam int RELAY_SLOTS = 4;
   localparam int SLOT_W      = 2;
   localparam int STATUS_W    = 4;
   localparam int HOPS_W      = 4;
   localparam int KEY_W       = 32;

   // request commands
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // CSR index (word offset bit)
   localparam logic CSR_RSSI_FLOOR = 1'b0;
   localparam logic CSR_ADDR_ONLY  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 4'd0;
   localparam logic [STATUS_W-1:0] STAT_QUEUED = 4'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 4'd2;
   localparam logic [STATUS_W-1:0] STAT_CRC    = 4'd3;
   localparam logic [STATUS_W-1:0] STAT_DUP    = 4'd4;
   localparam logic [STATUS_W-1:0] STAT_AUTH   = 4'd5;
   localparam logic [STATUS_W-1:0] STAT_WEAK   = 4'd6;
   localparam logic [STATUS_W-1:0] STAT_DUE    = 4'd7;
   localparam logic [STATUS_W-1:0] STAT_NONE   = 4'd8;

   // lookup request to the seen-key unit
   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] key;
   } seen_req_type;

   // lookup response: done pulses once, hit valid with it
   typedef struct packed {
      logic done;
      logic hit;
   } seen_rsp_type;

endpackage

// File: design/flood_relay_filter_core.sv
// Flood relay filter, top level: handshake, CSRs, check sequence, relay slots.
// Depends on frf_pkg and frf_seen.
`timescale 1ns / 1ps

// One item is processed at a time. A packet header beat with a good CRC
// searches the seen-key ring one memory read per cycle, reading at most
// SEEN_DEPTH entries (the current fill); a header beat with a bad CRC goes
// straight to its result. A tick beat walks the 4 relay slots one per cycle
// while the output register is free, as rsp_ready can hold off its result
// beats. Results pass through an output register, so a new request beat is
// accepted while the last result of the previous one still waits. The seen
// ring starts empty after reset through a fill count, with no clearing pass;
// the first item can be accepted right after reset. CSRs: offset 0x0
// rssi_floor (signed 8 bit, reset -120), offset 0x4 addr_only (reset 0).
module flood_relay_filter_core #(
   parameter int SEEN_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [15:0]                    req_sender_hash,
   input  logic [15:0]                    req_msg_id,
   input  logic                           req_crc_ok,
   input  logic                           req_auth_ok,
   input  logic signed [7:0]              req_rssi,
   input  logic [3:0]                     req_hop_count,
   input  logic                           req_addressed_to_local,
   input  logic [10:0]                    req_cooldown_ms,
   input  logic [31:0]                    req_now_ms,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [frf_pkg::STATUS_W-1:0]   rsp_status,
   output logic [frf_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [frf_pkg::HOPS_W-1:0]     rsp_relay_hops,
   output logic                           rsp_last,
   // APB-style CSR port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   import frf_pkg::*;

   // control states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SEEN = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   // ---------------------------------------------------------------- CSRs
   logic signed [7:0] rssi_thr_ff;
   logic              addr_only_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rssi_thr_ff  <= -8'sd120;
         addr_only_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_RSSI_FLOOR: rssi_thr_ff  <= pwdata[7:0];
            CSR_ADDR_ONLY:  addr_only_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_RSSI_FLOOR: prdata = {{24{rssi_thr_ff[7]}}, rssi_thr_ff};
         CSR_ADDR_ONLY:  prdata = {31'b0, addr_only_ff};
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------- seen-key unit
   seen_req_type seen_req;
   seen_rsp_type seen_rsp;

   frf_seen #(
      .SEEN_DEPTH(SEEN_DEPTH)
   ) u_seen (
      .clock    (clock),
      .reset    (reset),
      .seen_req (seen_req),
      .seen_rsp (seen_rsp)
   );

   // ------------------------------------------------------------- state
   logic [1:0]              state_ff, state_in;

   // latched request fields
   logic                    item_auth_ff, item_auth_in;
   logic signed [7:0]       item_rssi_ff, item_rssi_in;
   logic [3:0]              item_hops_ff, item_hops_in;
   logic                    item_addr_ff, item_addr_in;
   logic [10:0]             item_cool_ff, item_cool_in;
   logic [31:0]             item_now_ff, item_now_in;

   // relay slots (few entries, kept in flops)
   logic [RELAY_SLOTS-1:0]  slot_pending_ff, slot_pending_in;
   logic [31:0]             slot_deadline_ff [RELAY_SLOTS];
   logic [HOPS_W-1:0]       slot_hops_ff [RELAY_SLOTS];
   logic                    slot_wr;
   logic [SLOT_W-1:0]       slot_wr_idx;

   // tick walk
   logic [SLOT_W-1:0]       tick_idx_ff, tick_idx_in;
   logic                    held_vld_ff, held_vld_in;
   logic [SLOT_W-1:0]       held_slot_ff, held_slot_in;
   logic [HOPS_W-1:0]       held_hops_ff, held_hops_in;

   // final result waiting for the output register
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic [HOPS_W-1:0]       res_hops_ff, res_hops_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [HOPS_W-1:0]       rsp_hops_ff, rsp_hops_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_load;
   logic                    out_free;

   logic                    req_fire;
   logic                    free_found;
   logic [SLOT_W-1:0]       free_idx;
   logic [31:0]             tick_diff;
   logic                    tick_due;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lookup starts the same cycle a good-CRC header beat is taken
   assign seen_req.start = req_fire && (req_cmd == CMD_HEADER) && req_crc_ok;
   assign seen_req.key   = {req_sender_hash, req_msg_id};

   // lowest free slot
   always_comb begin
      free_found = |(~slot_pending_ff);
      free_idx   = '0;
      for (int i = RELAY_SLOTS - 1; i >= 0; i--) begin
         if (!slot_pending_ff[i])
            free_idx = SLOT_W'(i);
      end
   end

   // due when (now - deadline) is not negative, wrap-safe
   assign tick_diff = item_now_ff - slot_deadline_ff[tick_idx_ff];
   assign tick_due  = slot_pending_ff[tick_idx_ff] && !tick_diff[31];

   always_comb begin
      state_in        = state_ff;
      item_auth_in    = item_auth_ff;
      item_rssi_in    = item_rssi_ff;
      item_hops_in    = item_hops_ff;
      item_addr_in    = item_addr_ff;
      item_cool_in    = item_cool_ff;
      item_now_in     = item_now_ff;
      slot_pending_in = slot_pending_ff;
      slot_wr         = 1'b0;
      slot_wr_idx     = free_idx;
      tick_idx_in     = tick_idx_ff;
      held_vld_in     = held_vld_ff;
      held_slot_in    = held_slot_ff;
      held_hops_in    = held_hops_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_hops_in     = res_hops_ff;
      rsp_load        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_hops_in     = rsp_hops_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               item_auth_in = req_auth_ok;
               item_rssi_in = req_rssi;
               item_hops_in = req_hop_count;
               item_addr_in = req_addressed_to_local;
               item_cool_in = req_cooldown_ms;
               item_now_in  = req_now_ms;
               res_slot_in  = '0;
               res_hops_in  = '0;
               if (req_cmd == CMD_TICK) begin
                  tick_idx_in = '0;
                  held_vld_in = 1'b0;
                  state_in    = S_TICK;
               end else if (!req_crc_ok) begin
                  res_status_in = STAT_CRC;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_SEEN;
               end
            end
         end

         S_SEEN: begin
            if (seen_rsp.done) begin
               state_in = S_EMIT;
               // key is already inserted on a miss
               if (seen_rsp.hit)
                  res_status_in = STAT_DUP;
               else if (!item_auth_ff)
                  res_status_in = STAT_AUTH;
               else if (item_rssi_ff < rssi_thr_ff)
                  res_status_in = STAT_WEAK;
               else if (item_hops_ff == '0 || (addr_only_ff && !item_addr_ff))
                  res_status_in = STAT_OK;
               else if (!free_found)
                  res_status_in = STAT_FULL;
               else begin
                  res_status_in             = STAT_QUEUED;
                  res_slot_in               = free_idx;
                  res_hops_in               = item_hops_ff - 1'b1;
                  slot_wr                   = 1'b1;
                  slot_pending_in[free_idx] = 1'b1;
               end
            end
         end

         S_TICK: begin
            // a due slot is held one step so the last one can carry last=1
            if (out_free) begin
               if (tick_due) begin
                  slot_pending_in[tick_idx_ff] = 1'b0;
                  if (held_vld_ff) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STAT_DUE;
                     rsp_slot_in   = held_slot_ff;
                     rsp_hops_in   = held_hops_ff;
                     rsp_last_in   = 1'b0;
                  end
                  held_vld_in  = 1'b1;
                  held_slot_in = tick_idx_ff;
                  held_hops_in = slot_hops_ff[tick_idx_ff];
               end
               if (tick_idx_ff == SLOT_W'(RELAY_SLOTS - 1)) begin
                  state_in      = S_EMIT;
                  res_status_in = held_vld_in ? STAT_DUE : STAT_NONE;
                  res_slot_in   = held_vld_in ? held_slot_in : '0;
                  res_hops_in   = held_vld_in ? held_hops_in : '0;
               end else begin
                  tick_idx_in = tick_idx_ff + 1'b1;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_hops_in   = res_hops_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         slot_pending_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         held_vld_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slot_pending_ff <= slot_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
         held_vld_ff     <= held_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_auth_ff  <= item_auth_in;
      item_rssi_ff  <= item_rssi_in;
      item_hops_ff  <= item_hops_in;
      item_addr_ff  <= item_addr_in;
      item_cool_ff  <= item_cool_in;
      item_now_ff   <= item_now_in;
      tick_idx_ff   <= tick_idx_in;
      held_slot_ff  <= held_slot_in;
      held_hops_ff  <= held_hops_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_hops_ff   <= res_hops_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hops_ff   <= rsp_hops_in;
      rsp_last_ff   <= rsp_last_in;
      if (slot_wr) begin
         slot_deadline_ff[slot_wr_idx] <= item_now_ff + 32'(item_cool_ff);
         slot_hops_ff[slot_wr_idx]     <= item_hops_ff - 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_relay_hops = rsp_hops_ff;
   assign rsp_last       = rsp_last_ff;

   // ---------------------------------------------------------- checks
   a_seen_done_state: assert property (@(posedge clock) disable iff (reset)
      seen_rsp.done |-> (state_ff == S_SEEN))
      else $error("seen lookup finished outside lookup wait");

   a_only_due_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_DUE) |-> rsp_last_ff)
      else $error("single-result status without last");

   a_release_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_TICK) |=>
         ($countones(slot_pending_ff) >= $past($countones(slot_pending_ff))))
      else $error("relay slot freed outside a tick");

endmodule

// File: design/frf_seen.sv
// Seen-key ring: memory of recent keys, linear search and insert on miss.
// Depends on frf_pkg.
`timescale 1ns / 1ps

module frf_seen #(
   parameter int SEEN_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  frf_pkg::seen_req_type seen_req,
   output frf_pkg::seen_rsp_type seen_rsp
);

   import frf_pkg::*;

   localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int CW = $clog2(SEEN_DEPTH + 1);

   localparam logic SN_IDLE = 1'b0;
   localparam logic SN_SCAN = 1'b1;

   logic [KEY_W-1:0] key_mem [SEEN_DEPTH];

   logic             state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [KEY_W-1:0] rd_data_ff;
   logic             done_ff, done_in;
   logic             hit_ff, hit_in;

   logic issue, hit_now, finish, wr_en;

   assign issue   = (cnt_ff < fill_ff);
   assign hit_now = rd_vld_ff && (rd_data_ff == key_ff);
   assign finish  = hit_now || (!issue && !rd_vld_ff);

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      rd_vld_in = 1'b0;
      done_in   = 1'b0;
      hit_in    = hit_ff;
      wr_en     = 1'b0;
      unique case (state_ff)
         SN_IDLE: begin
            if (seen_req.start) begin
               key_in   = seen_req.key;
               cnt_in   = '0;
               state_in = SN_SCAN;
            end
         end
         SN_SCAN: begin
            if (finish) begin
               done_in  = 1'b1;
               hit_in   = hit_now;
               state_in = SN_IDLE;
               if (!hit_now) begin
                  // new key overwrites the oldest entry
                  wr_en  = 1'b1;
                  ptr_in = (ptr_ff == AW'(SEEN_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
                  if (fill_ff != CW'(SEEN_DEPTH))
                     fill_in = fill_ff + 1'b1;
               end
            end else if (issue) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         default: state_in = SN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SN_IDLE;
         fill_ff   <= '0;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      hit_ff <= hit_in;
   end

   // single-port style: one read or one write per cycle
   always_ff @(posedge clock) begin
      if (rd_vld_in)
         rd_data_ff <= key_mem[cnt_ff[AW-1:0]];
      if (wr_en)
         key_mem[ptr_ff] <= key_ff;
   end

   assign seen_rsp.done = done_ff;
   assign seen_rsp.hit  = hit_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(SEEN_DEPTH))
      else $error("seen fill count past depth");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != CW'(SEEN_DEPTH)) |-> (CW'(ptr_ff) == fill_ff))
      else $error("insert pointer out of step with fill count");

   a_miss_grows: assert property (@(posedge clock) disable iff (reset)
      (done_in && !hit_in && fill_ff != CW'(SEEN_DEPTH)) |=>
         (fill_ff == $past(fill_ff) + 1'b1))
      else $error("miss did not insert key");

endmodule
